// ===== design/sam_pkg.sv =====
package sam_pkg;

  localparam int NUM_OBJECTS = 128;
  localparam int OBJ_W       = $clog2(NUM_OBJECTS);
  localparam int GROUPS      = NUM_OBJECTS / 4;
  localparam int GROUP_W     = $clog2(GROUPS);

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_SIZE   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  localparam logic CFG_BASE_SIZE = 1'b0;
  localparam logic CFG_INTERLACE = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] address;
    logic [7:0] data;
    logic [6:0] object_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] width;
    logic [6:0] height;
  } out_item_t;

  // what stage one keeps of an item besides the memory read data
  typedef struct packed {
    logic [1:0] mode;
    logic       hi_sel;
    logic [1:0] lane;
    logic [1:0] obj_sub;
  } s1_item_t;

  typedef struct packed {
    logic [6:0] width;
    logic [6:0] height;
  } dims_t;

  localparam logic [6:0] SMALL_W [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd16, 7'd16};
  localparam logic [6:0] SMALL_H [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd32, 7'd32};
  localparam logic [6:0] LARGE_W [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd32, 7'd32};
  localparam logic [6:0] LARGE_H [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd64, 7'd32};

  function automatic dims_t sam_dims(input logic [2:0] base, input logic ilace,
                                     input logic is_large);
    dims_t d;
    if (is_large) begin
      d.width  = LARGE_W[base];
      d.height = LARGE_H[base];
    end else begin
      d.width  = SMALL_W[base];
      // interlace halves small height in base sizes 6 and 7
      d.height = (ilace && base[2] && base[1]) ? 7'd16 : SMALL_H[base];
    end
    return d;
  endfunction

endpackage

// ===== design/sprite_attribute_memory_top.sv =====
// pipeline: memory read, then result register; out_ready low stalls both
// throughput: 1 item per cycle while out_ready does not stall; a write lands in the store at its accept edge
// reset (rst_n low, synchronous): pipeline emptied, base size and interlace cleared,
// every row of both stores marked unwritten so it reads as zero; no clearing pass
module sprite_attribute_memory_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sam_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sam_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [2:0]          cfg_wdata
);
  import sam_pkg::*;

  logic              accept;
  logic              s1_valid_r;
  s1_item_t          s1_item_r;
  s1_item_t          s1_item_nxt;
  logic              s1_ready;
  logic [2:0]        base_size_r;
  logic              interlace_r;
  logic [31:0]       low_row;
  logic [7:0]        high_row;
  logic              is_write;
  logic [GROUP_W-1:0] hi_rd_row;

  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;
  assign is_write = accept && (in_item.mode == MODE_WRITE);

  // size queries look up the size bit through the high table row of the object
  assign hi_rd_row = (in_item.mode == MODE_SIZE) ? in_item.object_index[OBJ_W-1:2]
                                                 : in_item.address[GROUP_W-1:0];

  sam_low_mem u_low_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (is_write && !in_item.address[9]),
    .wr_row  (in_item.address[OBJ_W+1:2]),
    .wr_lane (in_item.address[1:0]),
    .wr_data (in_item.data),
    .rd_en   (accept),
    .rd_row  (in_item.address[OBJ_W+1:2]),
    .rd_data (low_row)
  );

  sam_high_mem u_high_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (is_write && in_item.address[9]),
    .wr_row  (in_item.address[GROUP_W-1:0]),
    .wr_data (in_item.data),
    .rd_en   (accept),
    .rd_row  (hi_rd_row),
    .rd_data (high_row)
  );

  always_comb begin
    s1_item_nxt.mode    = in_item.mode;
    s1_item_nxt.hi_sel  = in_item.address[9];
    s1_item_nxt.lane    = in_item.address[1:0];
    s1_item_nxt.obj_sub = in_item.object_index[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r <= 3'd0;
      interlace_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_SIZE) begin
        base_size_r <= cfg_wdata;
      end else if (cfg_index == CFG_INTERLACE) begin
        interlace_r <= cfg_wdata[0];
      end
    end
  end

  sam_result_stage u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_item   (s1_item_r),
    .low_row   (low_row),
    .high_row  (high_row),
    .base_size (base_size_r),
    .interlace (interlace_r),
    .s1_ready  (s1_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== design/sam_low_mem.sv =====
module sam_low_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [sam_pkg::OBJ_W-1:0]  wr_row,
  input  logic [1:0]                 wr_lane,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [sam_pkg::OBJ_W-1:0]  rd_row,
  output logic [31:0]                rd_data
);
  import sam_pkg::*;

  logic [31:0]            mem [NUM_OBJECTS];
  logic [NUM_OBJECTS-1:0] valid_r;
  logic [31:0]            rdata_r;
  logic                   rvalid_r;

  // a row never written reads as zero; first write zero-fills the other bytes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < 4; i++) begin
        if ((wr_lane == i[1:0]) || !valid_r[wr_row]) begin
          mem[wr_row][i*8 +: 8] <= (wr_lane == i[1:0]) ? wr_data : 8'd0;
        end
      end
    end
    if (rd_en) begin
      rdata_r <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_r <= valid_r[rd_row];
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : 32'd0;

endmodule

// ===== design/sam_high_mem.sv =====
module sam_high_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [sam_pkg::GROUP_W-1:0]  wr_row,
  input  logic [7:0]                   wr_data,
  input  logic                         rd_en,
  input  logic [sam_pkg::GROUP_W-1:0]  rd_row,
  output logic [7:0]                   rd_data
);
  import sam_pkg::*;

  // row g: bit 2k is x bit 8 and bit 2k+1 the size bit of object 4g+k
  logic [7:0]        mem [GROUPS];
  logic [GROUPS-1:0] valid_r;
  logic [7:0]        rdata_r;
  logic              rvalid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_r <= valid_r[rd_row];
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : 8'd0;

endmodule

// ===== design/sam_result_stage.sv =====
module sam_result_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  sam_pkg::s1_item_t    s1_item,
  input  logic [31:0]          low_row,
  input  logic [7:0]           high_row,
  input  logic [2:0]           base_size,
  input  logic                 interlace,
  output logic                 s1_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sam_pkg::out_item_t   out_item
);
  import sam_pkg::*;

  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic [7:0] low_byte;
  dims_t     dims;

  always_comb begin
    case (s1_item.lane)
      2'd0:    low_byte = low_row[7:0];
      2'd1:    low_byte = low_row[15:8];
      2'd2:    low_byte = low_row[23:16];
      default: low_byte = low_row[31:24];
    endcase
  end

  assign dims = sam_dims(base_size, interlace, high_row[{s1_item.obj_sub, 1'b1}]);

  always_comb begin
    out_item_nxt = '0;
    case (s1_item.mode)
      MODE_READ: begin
        out_item_nxt.read_data = s1_item.hi_sel ? high_row : low_byte;
      end
      MODE_SIZE: begin
        out_item_nxt.width  = dims.width;
        out_item_nxt.height = dims.height;
      end
      default: begin
        out_item_nxt = '0;
      end
    endcase
  end

  assign s1_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
